// File: rtl/core/lrs_pkg.sv
// Shared constants and types for the linear interpolation resampler.
// Used by every module under rtl/core except lrs_fifo; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 16;
	localparam int STEP_BITS   = 23;
	localparam int COUNT_BITS  = 32;
	localparam int MAX_RESULTS = 64;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [STEP_BITS-1:0]  STEP_RESET  = 23'd65536;
	localparam logic [COUNT_BITS-1:0] COUNT_RESET = 32'd0;

	localparam logic REG_STEP  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef struct packed {
		logic pair;
		logic last;
		logic neg;
	} cmd_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/lrs_fifo.sv
// Small register queue between the front and back parts of the resampler.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lrs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/lrs_front.sv
// Front part: accepts source samples, keeps the previous one and queues
// interpolation commands. Depends on lrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrs_front #(
	parameter int SAMPLE_BITS = lrs_pkg::SAMPLE_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] in_sample,
	input  wire logic                   in_last,
	input  wire logic                   q_full,
	output logic                        q_push,
	output lrs_pkg::cmd_ctl_t           q_ctl,
	output logic      [SAMPLE_BITS-1:0] q_a,
	output logic      [SAMPLE_BITS-1:0] q_b,
	output logic      [SAMPLE_BITS-1:0] q_mag
);

	logic [SAMPLE_BITS-1:0] prev_q;
	logic                   have_q;
	logic                   accept;
	logic [SAMPLE_BITS:0]   diff_ba;
	logic [SAMPLE_BITS:0]   diff_ab;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept && (have_q || in_last);

	assign diff_ba = {in_sample[SAMPLE_BITS-1], in_sample} - {prev_q[SAMPLE_BITS-1], prev_q};
	assign diff_ab = {prev_q[SAMPLE_BITS-1], prev_q} - {in_sample[SAMPLE_BITS-1], in_sample};

	assign q_ctl.pair = have_q;
	assign q_ctl.last = in_last;
	assign q_ctl.neg  = diff_ba[SAMPLE_BITS];
	assign q_a        = prev_q;
	assign q_b        = in_sample;
	assign q_mag      = diff_ba[SAMPLE_BITS] ? diff_ab[SAMPLE_BITS-1:0]
	                                         : diff_ba[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			have_q <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				prev_q <= '0;
				have_q <= 1'b0;
			end else begin
				prev_q <= in_sample;
				have_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/lrs_back.sv
// Back part: walks output positions per command, interpolates through a
// multiply pipeline and holds one result to mark the end of each run.
// Depends on lrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrs_back #(
	parameter int SAMPLE_BITS = lrs_pkg::SAMPLE_BITS,
	parameter int FRAC_BITS   = lrs_pkg::FRAC_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [lrs_pkg::STEP_BITS-1:0]  step,
	input  wire logic [lrs_pkg::COUNT_BITS-1:0] out_count,
	input  wire logic                           q_empty,
	output logic                                q_pop,
	input  wire lrs_pkg::cmd_ctl_t              q_ctl,
	input  wire logic [SAMPLE_BITS-1:0]         q_a,
	input  wire logic [SAMPLE_BITS-1:0]         q_b,
	input  wire logic [SAMPLE_BITS-1:0]         q_mag,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [SAMPLE_BITS-1:0]         out_sample,
	output logic                                out_run_end,
	output logic                                out_chan_end
);

	localparam int STEP_BITS  = lrs_pkg::STEP_BITS;
	localparam int COUNT_BITS = lrs_pkg::COUNT_BITS;
	localparam int PHASE_BITS = ((FRAC_BITS > STEP_BITS) ? FRAC_BITS : STEP_BITS) + 1;
	localparam int CNT_W      = $clog2(lrs_pkg::MAX_RESULTS + 1);
	localparam int PROD_W     = SAMPLE_BITS + FRAC_BITS;

	localparam logic [PHASE_BITS-1:0] ONE_POS   = PHASE_BITS'(1) << FRAC_BITS;
	localparam logic [PROD_W:0]       ROUND_ADD = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PAIR = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;
	localparam logic [1:0] ST_TAIL = 2'd3;

	logic [1:0]             st_q;
	logic [1:0]             nst;
	logic [PHASE_BITS-1:0]  phase_q;
	logic [COUNT_BITS-1:0]  idx_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SAMPLE_BITS-1:0] a_q;
	logic [SAMPLE_BITS-1:0] b_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic                   neg_q;
	logic                   last_q;

	logic                   go;
	logic                   in_unit;
	logic                   left;
	logic                   full;
	logic                   chend;
	logic [STEP_BITS-1:0]   st_eff;
	logic                   adv;
	logic                   fin;
	logic                   pair_end;
	logic                   tok_fv;
	logic                   tok_dn;
	logic [SAMPLE_BITS-1:0] tok_a;
	logic [SAMPLE_BITS-1:0] tok_mag;
	logic                   tok_neg;

	logic                   fv_s1, dn_s1, chend_s1, neg_s1;
	logic [SAMPLE_BITS-1:0] a_s1, mag_s1;
	logic [FRAC_BITS-1:0]   frac_s1;
	logic                   fv_s2, dn_s2, chend_s2, neg_s2;
	logic [SAMPLE_BITS-1:0] a_s2;
	logic [PROD_W-1:0]      prod_s2;
	logic                   fv_s3, dn_s3, chend_s3;
	logic [SAMPLE_BITS-1:0] res_s3;

	logic [PROD_W:0]        rsum;
	logic [SAMPLE_BITS:0]   rmag;
	logic [SAMPLE_BITS:0]   a_ext;
	logic [SAMPLE_BITS:0]   res_w;

	logic                   pend_v_q;
	logic [SAMPLE_BITS-1:0] pend_sample_q;
	logic                   pend_chend_q;
	logic                   out_v_q;
	logic [SAMPLE_BITS-1:0] out_sample_q;
	logic                   out_run_end_q;
	logic                   out_chan_end_q;

	assign go      = !out_v_q || out_ready;
	assign in_unit = (phase_q[PHASE_BITS-1:FRAC_BITS] == '0);
	assign left    = (idx_q < out_count);
	assign full    = (cnt_q == CNT_W'(lrs_pkg::MAX_RESULTS));
	assign chend   = (idx_q == out_count - 1'b1);
	assign st_eff  = (step == '0) ? STEP_BITS'(1) : step;
	assign q_pop   = go && (st_q == ST_IDLE) && !q_empty;

	always_comb begin
		nst      = st_q;
		adv      = 1'b0;
		fin      = 1'b0;
		pair_end = 1'b0;
		tok_fv   = 1'b0;
		tok_dn   = 1'b0;
		tok_a    = '0;
		tok_mag  = '0;
		tok_neg  = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (!q_empty) begin
					nst = q_ctl.pair ? ST_PAIR : ST_HOLD;
				end
			end
			ST_PAIR: begin
				tok_a   = a_q;
				tok_mag = mag_q;
				tok_neg = neg_q;
				if (last_q && full) begin
					fin = 1'b1;
				end else if (in_unit && left) begin
					adv    = 1'b1;
					tok_fv = !full;
				end else begin
					pair_end = 1'b1;
					if (last_q) begin
						nst = ST_HOLD;
					end else begin
						tok_dn = 1'b1;
						nst    = ST_IDLE;
					end
				end
			end
			ST_HOLD: begin
				tok_a = b_q;
				if (full) begin
					fin = 1'b1;
				end else if (in_unit && left) begin
					adv    = 1'b1;
					tok_fv = 1'b1;
				end else begin
					nst = ST_TAIL;
				end
			end
			ST_TAIL: begin
				if (full || !left) begin
					fin = 1'b1;
				end else begin
					adv    = 1'b1;
					tok_fv = 1'b1;
				end
			end
			default: begin
				nst = ST_IDLE;
			end
		endcase
		if (fin) begin
			tok_dn = 1'b1;
			nst    = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			phase_q <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			last_q  <= 1'b0;
		end else if (go) begin
			st_q <= nst;
			if (q_pop) begin
				cnt_q  <= '0;
				last_q <= q_ctl.last;
			end else if (adv && tok_fv) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (fin) begin
				phase_q <= '0;
				idx_q   <= '0;
			end else if (adv) begin
				phase_q <= phase_q + PHASE_BITS'(st_eff);
				idx_q   <= idx_q + 1'b1;
			end else if (pair_end) begin
				phase_q <= in_unit ? '0 : phase_q - ONE_POS;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			a_q   <= q_a;
			b_q   <= q_b;
			mag_q <= q_mag;
			neg_q <= q_ctl.neg;
		end
	end

	// interpolation pipeline
	assign rsum  = {1'b0, prod_s2} + ROUND_ADD;
	assign rmag  = rsum[PROD_W:FRAC_BITS];
	assign a_ext = {a_s2[SAMPLE_BITS-1], a_s2};
	assign res_w = neg_s2 ? a_ext - rmag : a_ext + rmag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_s1 <= 1'b0;
			dn_s1 <= 1'b0;
			fv_s2 <= 1'b0;
			dn_s2 <= 1'b0;
			fv_s3 <= 1'b0;
			dn_s3 <= 1'b0;
		end else if (go) begin
			fv_s1 <= tok_fv;
			dn_s1 <= tok_dn;
			fv_s2 <= fv_s1;
			dn_s2 <= dn_s1;
			fv_s3 <= fv_s2;
			dn_s3 <= dn_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			chend_s1 <= chend;
			a_s1     <= tok_a;
			mag_s1   <= tok_mag;
			neg_s1   <= tok_neg;
			frac_s1  <= phase_q[FRAC_BITS-1:0];
			chend_s2 <= chend_s1;
			a_s2     <= a_s1;
			neg_s2   <= neg_s1;
			prod_s2  <= PROD_W'(mag_s1) * PROD_W'(frac_s1);
			chend_s3 <= chend_s2;
			res_s3   <= res_w[SAMPLE_BITS-1:0];
		end
	end

	// hold one result until the next one or the end of its run shows up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else if (go) begin
			if (fv_s3) begin
				out_v_q  <= pend_v_q;
				pend_v_q <= 1'b1;
			end else if (dn_s3) begin
				out_v_q  <= pend_v_q;
				pend_v_q <= 1'b0;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_sample_q   <= pend_sample_q;
			out_chan_end_q <= pend_chend_q;
			out_run_end_q  <= dn_s3;
			if (fv_s3) begin
				pend_sample_q <= res_s3;
				pend_chend_q  <= chend_s3;
			end
		end
	end

	assign out_valid    = out_v_q;
	assign out_sample   = out_sample_q;
	assign out_run_end  = out_run_end_q;
	assign out_chan_end = out_chan_end_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(lrs_pkg::MAX_RESULTS))
		else $error("result count past limit");

	a_tail_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_HOLD || st_q == ST_TAIL) |-> last_q)
		else $error("hold or tail walk without a last sample");

	a_token_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!(fv_s1 && dn_s1))
		else $error("frame and end marker in one token");

	a_run_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(go && dn_s3) |=> !pend_v_q)
		else $error("held result survives end of run");

	a_pop_load: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (st_q == ST_PAIR || st_q == ST_HOLD))
		else $error("command fetch did not start a walk");

endmodule

`default_nettype wire

// File: rtl/core/linear_interp_resampler.sv
// Linear interpolation sample rate converter, one channel at a time.
//
// Slave stream s_*: one source sample per transfer, s_tlast on the final
// sample of a channel. Master stream m_*: interpolated samples, m_tlast on
// the last result caused by one source sample, m_tuser on the final output
// frame of the channel. APB port: step at 0x0 (23 bits, 16 fraction bits,
// source frames per output frame) and out_count at 0x4 (frames per channel).
// Write registers only while the block is idle.
// The position walker in the back part handles a source sample as a command
// fetch, a walk over each output position it covers (emitted or dropped
// past 64) and a closing step, and fetches no new command before the walk ends.
// A final sample also walks the frames that hold the last value and the
// zero-filled remainder, at most 64 results per sample.
// Results pass stages s1 to s3, the held-result and the output register.
// A four-entry command queue lets intake continue while results wait.
// Reset clears the channel state, step to unity and out_count to zero.
// While m_tvalid is high and m_tready low the back part holds; the front
// keeps accepting samples until the queue is full.
// Depends on lrs_pkg, lrs_fifo, lrs_front and lrs_back.
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_resampler #(
	parameter int SAMPLE_BITS = lrs_pkg::SAMPLE_BITS,
	parameter int FRAC_BITS   = lrs_pkg::FRAC_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // sample_in
	input  wire logic                                 s_tlast,  // last_in
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic      [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,  // sample_out
	output logic                                      m_tlast,  // run_end
	output logic                                      m_tuser,  // channel_end
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [2:0]                           paddr,
	input  wire logic [31:0]                          pwdata,
	output logic      [31:0]                          prdata,
	output logic                                      pready
);

	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int CTL_W   = $bits(lrs_pkg::cmd_ctl_t);
	localparam int CMD_W   = CTL_W + 3 * SAMPLE_BITS;

	logic [lrs_pkg::STEP_BITS-1:0]  step_q;
	logic [lrs_pkg::COUNT_BITS-1:0] out_count_q;
	logic                           cfg_wr;

	logic                   q_push, q_pop, q_full, q_empty;
	lrs_pkg::cmd_ctl_t      push_ctl, pop_ctl;
	logic [SAMPLE_BITS-1:0] push_a, push_b, push_mag;
	logic [SAMPLE_BITS-1:0] pop_a, pop_b, pop_mag;
	logic [CMD_W-1:0]       pop_data;
	logic [SAMPLE_BITS-1:0] out_sample;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= lrs_pkg::STEP_RESET;
			out_count_q <= lrs_pkg::COUNT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				lrs_pkg::REG_STEP:  step_q      <= pwdata[lrs_pkg::STEP_BITS-1:0];
				lrs_pkg::REG_COUNT: out_count_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			lrs_pkg::REG_STEP:  prdata = 32'(step_q);
			lrs_pkg::REG_COUNT: prdata = out_count_q;
			default:            prdata = '0;
		endcase
	end

	lrs_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_sample(s_tdata[SAMPLE_BITS-1:0]),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_ctl    (push_ctl),
		.q_a      (push_a),
		.q_b      (push_b),
		.q_mag    (push_mag)
	);

	lrs_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(lrs_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_data({push_ctl, push_a, push_b, push_mag}),
		.pop    (q_pop),
		.rd_data(pop_data),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {pop_ctl, pop_a, pop_b, pop_mag} = pop_data;

	lrs_back #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step_q),
		.out_count   (out_count_q),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.q_ctl       (pop_ctl),
		.q_a         (pop_a),
		.q_b         (pop_b),
		.q_mag       (pop_mag),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_sample  (out_sample),
		.out_run_end (m_tlast),
		.out_chan_end(m_tuser)
	);

	assign m_tdata = TDATA_W'(out_sample);

endmodule

`default_nettype wire
